// File: hw/rtl/wcf_pkg.sv
// ----------------------------------------------------------------------------
// wcf_pkg: shared types and constants of the window convolution filter
// Field widths, register codes, filter modes and the words passed between
// the front end, the job queue and the convolution engine.
// ----------------------------------------------------------------------------
package wcf_pkg;

   // fixed widths
   localparam int ROW_BITS      = 14;
   localparam int COL_BITS      = 13;
   localparam int GEO_W_BITS    = 14;
   localparam int GEO_H_BITS    = 13;
   localparam int LIN_BITS      = 28;
   localparam int RING_BITS     = 3;
   localparam int MODE_BITS     = 2;
   localparam int GAIN_BITS     = 4;
   localparam int PIX_BITS      = 24;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 13;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_FILTER_MODE  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CONTOUR_GAIN = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SHARPEN_GAIN = 3'd4;

   // filter modes (the unused code behaves as blur)
   localparam logic [MODE_BITS-1:0] MODE_BLUR    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CONTOUR = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_SHARPEN = 2'd2;

   // register reset values
   localparam logic [MODE_BITS-1:0] RST_FILTER_MODE  = MODE_BLUR;
   localparam logic [11:0]          RST_IMAGE_WIDTH  = 12'd640;
   localparam logic [12:0]          RST_IMAGE_HEIGHT = 13'd480;
   localparam logic [GAIN_BITS-1:0] RST_CONTOUR_GAIN = 4'd3;
   localparam logic [GAIN_BITS-1:0] RST_SHARPEN_GAIN = 4'd3;

   localparam logic [7:0] PIX_MAX = 8'd255;

   // effective geometry and gains seen by the engine
   typedef struct packed {
      logic [GEO_W_BITS-1:0] width;
      logic [GEO_H_BITS-1:0] height;
      logic [GAIN_BITS-1:0]  contour_gain;
      logic [GAIN_BITS-1:0]  sharpen_gain;
   } cfg_type;

   // one output pixel to compute
   typedef struct packed {
      logic [ROW_BITS-1:0]  row;
      logic [COL_BITS-1:0]  col;
      logic [RING_BITS-1:0] ring;
      logic [MODE_BITS-1:0] mode;
      logic                 last;
   } job_type;

   // line store write
   typedef struct packed {
      logic                 en;
      logic [RING_BITS-1:0] ring;
      logic [COL_BITS-1:0]  col;
      logic [PIX_BITS-1:0]  data;
   } store_wr_type;

   // result word
   typedef struct packed {
      logic       frame_last;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } out_word_type;

endpackage

// File: hw/rtl/window_convolution_filter.sv
// ----------------------------------------------------------------------------
// window_convolution_filter: streaming 5x5 blur, 3x3 contour and sharpen
// Top level: front end, job queue, convolution engine and result queue.
// ----------------------------------------------------------------------------
// Raster BGR pixels go in, filtered pixels come out lagging by the window
// radius in rows and columns; pad words drain the last rows. A word that
// yields no pixel does not hold the input side. A word that yields a pixel
// holds the input side until the engine is done with it, that is through
// the one-tap-per-cycle window sweep over the single line store read port
// and the bit-serial divide by the weight sum. Two results can wait in the
// output queue while the next word is worked on.
module window_convolution_filter
   import wcf_pkg::*;
#(
   parameter int MAX_WIDTH   = 2048,
   parameter int WINDOW_SIZE = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [7:0]               req_blue_in,
   input  logic [7:0]               req_green_in,
   input  logic [7:0]               req_red_in,
   input  logic                     req_is_pad,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [7:0]               rsp_blue_out,
   output logic [7:0]               rsp_green_out,
   output logic [7:0]               rsp_red_out,
   output logic                     rsp_frame_last,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);
   cfg_type      cfg;
   store_wr_type store_wr;
   job_type      job_in, job_out;
   logic         job_push, job_pop, job_full, job_empty;
   logic         back_busy, accept;
   logic         out_push, out_full;
   out_word_type out_word, out_head;

   // one word in flight: the store is not written while a job is pending
   assign req_full  = !job_empty || back_busy;
   assign accept    = req_push && !req_full;
   assign csr_ready = 1'b1;

   wcf_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .blue_in   (req_blue_in),
      .green_in  (req_green_in),
      .red_in    (req_red_in),
      .is_pad    (req_is_pad),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .store_wr  (store_wr),
      .job_push  (job_push),
      .job       (job_in)
   );

   // job queue between front and engine
   wcf_fifo #(
      .WIDTH ($bits(job_type)),
      .DEPTH (2)
   ) u_job_q (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out),
      .empty     (job_empty)
   );

   wcf_back #(
      .MAX_WIDTH   (MAX_WIDTH),
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .store_wr  (store_wr),
      .cfg       (cfg),
      .job_valid (!job_empty && !job_full || !job_empty),
      .job       (job_out),
      .job_pop   (job_pop),
      .busy      (back_busy),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_word  (out_word)
   );

   // result queue
   wcf_fifo #(
      .WIDTH ($bits(out_word_type)),
      .DEPTH (2)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_word),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_head),
      .empty     (rsp_empty)
   );

   assign rsp_blue_out   = out_head.blue;
   assign rsp_green_out  = out_head.green;
   assign rsp_red_out    = out_head.red;
   assign rsp_frame_last = out_head.frame_last;

endmodule

// File: hw/rtl/wcf_fifo.sv
// ----------------------------------------------------------------------------
// wcf_fifo: small synchronous queue
// Register based FIFO with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module wcf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNTW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/wcf_front.sv
// ----------------------------------------------------------------------------
// wcf_front: input front end
// Holds the registers, tracks input and output raster positions, writes
// pixels into the line store and issues one job per output pixel.
// ----------------------------------------------------------------------------
module wcf_front
   import wcf_pkg::*;
#(
   parameter int MAX_WIDTH   = 2048,
   parameter int WINDOW_SIZE = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               blue_in,
   input  logic [7:0]               green_in,
   input  logic [7:0]               red_in,
   input  logic                     is_pad,
   input  logic                     csr_write,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg,
   output store_wr_type             store_wr,
   output logic                     job_push,
   output job_type                  job
);
   localparam int                    RAD       = WINDOW_SIZE / 2;
   localparam logic [RING_BITS-1:0]  RING_LAST = RING_BITS'(WINDOW_SIZE - 1);
   localparam logic [GEO_W_BITS-1:0] MAX_W     = GEO_W_BITS'(MAX_WIDTH);

   logic [MODE_BITS-1:0] filter_mode_ff;
   logic [11:0]          image_width_ff;
   logic [12:0]          image_height_ff;
   logic [GAIN_BITS-1:0] contour_gain_ff, sharpen_gain_ff;

   logic [COL_BITS-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_BITS-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [RING_BITS-1:0] in_ring_ff, in_ring_in, out_ring_ff, out_ring_in;

   logic [GEO_W_BITS-1:0] w;
   logic [GEO_H_BITS-1:0] h;
   logic [1:0]            rad;
   logic                  clr, in_live, ignore, iwrap, owrap, emit, last;
   logic [COL_BITS-1:0]   ic, oc, ic_n, oc_n;
   logic [ROW_BITS-1:0]   ir, orow, ir_n, or_n;
   logic [RING_BITS-1:0]  iring, oring, iring_n, oring_n;
   logic [GEO_W_BITS-1:0] ic_inc, oc_inc;
   logic [LIN_BITS-1:0]   in_lin, out_lin, lag;

   // effective geometry
   always_comb begin
      if (image_width_ff == '0) begin
         w = GEO_W_BITS'(1);
      end else if (GEO_W_BITS'(image_width_ff) > MAX_W) begin
         w = MAX_W;
      end else begin
         w = GEO_W_BITS'(image_width_ff);
      end
      h = (image_height_ff == '0) ? GEO_H_BITS'(1) : image_height_ff;
   end

   assign cfg.width        = w;
   assign cfg.height       = h;
   assign cfg.contour_gain = contour_gain_ff;
   assign cfg.sharpen_gain = sharpen_gain_ff;

   assign rad = (filter_mode_ff == MODE_CONTOUR) ? 2'd1 : 2'(RAD);

   // raster position update for one accepted word
   always_comb begin
      clr   = (out_row_ff >= ROW_BITS'(h));
      ic    = clr ? '0 : in_col_ff;
      ir    = clr ? '0 : in_row_ff;
      iring = clr ? '0 : in_ring_ff;
      oc    = clr ? '0 : out_col_ff;
      orow  = clr ? '0 : out_row_ff;
      oring = clr ? '0 : out_ring_ff;

      in_live = (ir < ROW_BITS'(h));
      ignore  = in_live && is_pad;

      ic_inc  = GEO_W_BITS'(ic) + 1'b1;
      iwrap   = (ic_inc >= w);
      ic_n    = iwrap ? '0 : ic_inc[COL_BITS-1:0];
      ir_n    = iwrap ? ir + 1'b1 : ir;
      iring_n = iwrap ? ((iring == RING_LAST) ? '0 : iring + 1'b1) : iring;

      in_lin  = LIN_BITS'(ir_n) * LIN_BITS'(w) + LIN_BITS'(ic_n);
      out_lin = LIN_BITS'(orow) * LIN_BITS'(w) + LIN_BITS'(oc);
      lag     = LIN_BITS'(rad) * LIN_BITS'(w) + LIN_BITS'(rad);
      emit    = !ignore && (in_lin > out_lin + lag);

      oc_inc  = GEO_W_BITS'(oc) + 1'b1;
      owrap   = (oc_inc >= w);
      oc_n    = owrap ? '0 : oc_inc[COL_BITS-1:0];
      or_n    = owrap ? orow + 1'b1 : orow;
      oring_n = owrap ? ((oring == RING_LAST) ? '0 : oring + 1'b1) : oring;
      last    = (or_n >= ROW_BITS'(h));

      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_ring_in  = in_ring_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_ring_in = out_ring_ff;
      if (accept) begin
         if (ignore) begin
            in_col_in   = ic;
            in_row_in   = ir;
            in_ring_in  = iring;
            out_col_in  = oc;
            out_row_in  = orow;
            out_ring_in = oring;
         end else if (emit && last) begin
            in_col_in   = '0;
            in_row_in   = '0;
            in_ring_in  = '0;
            out_col_in  = '0;
            out_row_in  = '0;
            out_ring_in = '0;
         end else begin
            in_col_in   = ic_n;
            in_row_in   = ir_n;
            in_ring_in  = iring_n;
            out_col_in  = emit ? oc_n : oc;
            out_row_in  = emit ? or_n : orow;
            out_ring_in = emit ? oring_n : oring;
         end
      end
   end

   // line store write and job issue
   assign store_wr.en   = accept && in_live && !is_pad;
   assign store_wr.ring = iring;
   assign store_wr.col  = ic;
   assign store_wr.data = {red_in, green_in, blue_in};

   assign job_push = accept && emit;
   assign job.row  = orow;
   assign job.col  = oc;
   assign job.ring = oring;
   assign job.mode = filter_mode_ff;
   assign job.last = last;

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_ring_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_ring_ff <= '0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_ring_ff  <= in_ring_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_ring_ff <= out_ring_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff  <= RST_FILTER_MODE;
         image_width_ff  <= RST_IMAGE_WIDTH;
         image_height_ff <= RST_IMAGE_HEIGHT;
         contour_gain_ff <= RST_CONTOUR_GAIN;
         sharpen_gain_ff <= RST_SHARPEN_GAIN;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FILTER_MODE:  filter_mode_ff  <= csr_wdata[MODE_BITS-1:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[11:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[12:0];
            CSR_CONTOUR_GAIN: contour_gain_ff <= csr_wdata[GAIN_BITS-1:0];
            CSR_SHARPEN_GAIN: sharpen_gain_ff <= csr_wdata[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

endmodule

// File: hw/rtl/wcf_back.sv
// ----------------------------------------------------------------------------
// wcf_back: convolution engine
// Owns the line store. Per job it sweeps the window one tap a cycle,
// accumulates, divides by the weight sum bit-serially, clamps and sharpens.
// ----------------------------------------------------------------------------
module wcf_back
   import wcf_pkg::*;
#(
   parameter int MAX_WIDTH   = 2048,
   parameter int WINDOW_SIZE = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  store_wr_type store_wr,
   input  cfg_type      cfg,
   input  logic         job_valid,
   input  job_type      job,
   output logic         job_pop,
   output logic         busy,
   input  logic         out_full,
   output logic         out_push,
   output out_word_type out_word
);
   localparam int RAD   = WINDOW_SIZE / 2;
   localparam int DEPTH = WINDOW_SIZE * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int SUMW  = $clog2(WINDOW_SIZE * WINDOW_SIZE * 255 + 1);
   localparam int ACCW  = SUMW + 2;
   localparam int CNTW  = $clog2(WINDOW_SIZE * WINDOW_SIZE + 1);
   localparam int POSW  = $clog2(SUMW);
   localparam int PRDW  = SUMW + GAIN_BITS;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SWEEP = 6'b000010,
      ST_DRAIN = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_CLAMP = 6'b010000,
      ST_OUT   = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [PIX_BITS-1:0] store_mem [DEPTH];
   logic [PIX_BITS-1:0] rd_data_ff;
   logic [AW-1:0]       wr_addr, rd_addr;

   job_type             job_ff;
   logic [2:0]          ty_ff, ty_in, tx_ff, tx_in;
   logic                tap_vld_ff, tap_ctr_ff;
   logic signed [ACCW-1:0] acc_ff [3];
   logic [CNTW-1:0]     cnt_ff;
   logic [PIX_BITS-1:0] src_ff;
   logic [POSW-1:0]     pos_ff;
   logic [CNTW-1:0]     rem_ff [3];
   logic [SUMW-1:0]     quo_ff [3];
   logic [7:0]          res_ff [3];

   logic                contour;
   logic [2:0]          radj, span_last;
   logic signed [15:0]  yy, xx;
   logic signed [4:0]   ring_s;
   logic [RING_BITS-1:0] ring_w;
   logic                y_ok, x_ok, tap_issue, tap_ctr;
   logic [CNTW-1:0]     wraw, den;
   logic                sweep_done;

   // line store: one write port from the front, one read port here
   assign wr_addr = AW'(AW'(store_wr.ring) * AW'(MAX_WIDTH)) + AW'(store_wr.col);

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[wr_addr] <= store_wr.data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // window tap address and image bounds
   always_comb begin
      contour   = (job_ff.mode == MODE_CONTOUR);
      radj      = contour ? 3'd1 : 3'(RAD);
      span_last = radj << 1;
      yy = $signed(16'(job_ff.row)) + $signed(16'(ty_ff)) - $signed(16'(radj));
      xx = $signed(16'(job_ff.col)) + $signed(16'(tx_ff)) - $signed(16'(radj));
      y_ok = !yy[15] && (yy[14:0] < 15'(cfg.height));
      x_ok = !xx[15] && (xx[14:0] < 15'(cfg.width));
      ring_s = $signed(5'(job_ff.ring)) + $signed(5'(ty_ff)) - $signed(5'(radj));
      if (ring_s < 0) begin
         ring_w = RING_BITS'(ring_s + 5'(WINDOW_SIZE));
      end else if (ring_s >= $signed(5'(WINDOW_SIZE))) begin
         ring_w = RING_BITS'(ring_s - 5'(WINDOW_SIZE));
      end else begin
         ring_w = RING_BITS'(ring_s);
      end
      rd_addr    = AW'(AW'(ring_w) * AW'(MAX_WIDTH)) + AW'(xx[14:0]);
      tap_issue  = (state_ff == ST_SWEEP) && y_ok && x_ok;
      tap_ctr    = (ty_ff == radj) && (tx_ff == radj);
      sweep_done = (tx_ff == span_last) && (ty_ff == span_last);
      wraw       = CNTW'(9) - cnt_ff;
      den        = contour ? wraw : cnt_ff;
      if (den == '0) begin
         den = CNTW'(1);
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ty_in    = ty_ff;
      tx_in    = tx_ff;
      job_pop  = 1'b0;
      out_push = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               ty_in    = '0;
               tx_in    = '0;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (tx_ff == span_last) begin
               tx_in = '0;
               ty_in = ty_ff + 1'b1;
            end else begin
               tx_in = tx_ff + 1'b1;
            end
            if (sweep_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_DIV;
         ST_DIV: begin
            if (pos_ff == '0) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: state_in = ST_OUT;
         ST_OUT: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tap_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tap_vld_ff <= tap_issue;
      end
   end

   always_ff @(posedge clock) begin
      ty_ff      <= ty_in;
      tx_ff      <= tx_in;
      tap_ctr_ff <= tap_ctr;
      if (job_pop) begin
         job_ff <= job;
      end
   end

   // accumulate the tap read in the previous cycle
   always_ff @(posedge clock) begin
      if (job_pop) begin
         for (int k = 0; k < 3; k++) begin
            acc_ff[k] <= '0;
         end
         cnt_ff <= '0;
      end else if (tap_vld_ff) begin
         for (int k = 0; k < 3; k++) begin
            if (!contour) begin
               acc_ff[k] <= acc_ff[k] + $signed(ACCW'(rd_data_ff[8*k +: 8]));
            end else if (tap_ctr_ff) begin
               acc_ff[k] <= acc_ff[k] + ($signed(ACCW'(rd_data_ff[8*k +: 8])) <<< 3);
            end else begin
               acc_ff[k] <= acc_ff[k] - $signed(ACCW'(rd_data_ff[8*k +: 8]));
            end
         end
         cnt_ff <= cnt_ff + 1'b1;
         if (tap_ctr_ff) begin
            src_ff <= rd_data_ff;
         end
      end
   end

   // restoring divider, one quotient bit per cycle on all three channels
   always_ff @(posedge clock) begin
      logic [CNTW:0]   rem_sh;
      logic [SUMW-1:0] dvd;
      logic            ge;
      if (state_ff == ST_DRAIN) begin
         pos_ff <= POSW'(SUMW - 1);
         for (int k = 0; k < 3; k++) begin
            rem_ff[k] <= '0;
         end
      end else if (state_ff == ST_DIV) begin
         pos_ff <= pos_ff - 1'b1;
         for (int k = 0; k < 3; k++) begin
            dvd    = acc_ff[k][ACCW-1] ? '0 : acc_ff[k][SUMW-1:0];
            rem_sh = {rem_ff[k], dvd[pos_ff]};
            ge     = (rem_sh >= {1'b0, den});
            rem_ff[k] <= ge ? CNTW'(rem_sh - {1'b0, den}) : CNTW'(rem_sh);
            quo_ff[k] <= {quo_ff[k][SUMW-2:0], ge};
         end
      end
   end

   // mode specific result and first clamp
   always_ff @(posedge clock) begin
      logic [PRDW-1:0] base;
      if (state_ff == ST_CLAMP) begin
         for (int k = 0; k < 3; k++) begin
            if (!contour) begin
               base = PRDW'(quo_ff[k]);
            end else if (cfg.contour_gain == '0 || acc_ff[k][ACCW-1]) begin
               base = '0;
            end else if (wraw == '0) begin
               base = PRDW'(cfg.contour_gain) * PRDW'(acc_ff[k][SUMW-1:0]);
            end else begin
               base = PRDW'(quo_ff[k]);
            end
            res_ff[k] <= (base > PRDW'(PIX_MAX)) ? PIX_MAX : base[7:0];
         end
      end
   end

   // unsharp step and output word
   always_comb begin
      logic signed [9:0]  diff;
      logic signed [14:0] prod;
      logic signed [15:0] v;
      logic [7:0]         ch [3];
      for (int k = 0; k < 3; k++) begin
         diff = $signed({2'b0, src_ff[8*k +: 8]}) - $signed({2'b0, res_ff[k]});
         prod = 15'(diff) * $signed({11'b0, cfg.sharpen_gain});
         v    = 16'(prod) + $signed({8'b0, res_ff[k]});
         if (job_ff.mode != MODE_SHARPEN) begin
            ch[k] = res_ff[k];
         end else if (v < 0) begin
            ch[k] = '0;
         end else if (v > $signed({8'b0, PIX_MAX})) begin
            ch[k] = PIX_MAX;
         end else begin
            ch[k] = v[7:0];
         end
      end
      out_word.blue       = ch[0];
      out_word.green      = ch[1];
      out_word.red        = ch[2];
      out_word.frame_last = job_ff.last;
   end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: window convolution filter check
// Drives raster frames under blur, contour, sharpen and the spare mode code.
// Geometry and gains change between phases. A built-in pixel predictor holds
// the expected filtered words, and each popped word is checked against the
// oldest expected one.
// ----------------------------------------------------------------------------
module testbench;
   import wcf_pkg::*;

   localparam int  STORE_WIDTH = 2048;
   localparam int  SETTLE      = 60;
   localparam int  CYCLE_LIMIT = 3000000;
   localparam int  MAX_REPORTS = 10;

   // one input word plus the filtered word it should cause
   typedef struct {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       pad;
      bit         has_result;
      logic [7:0] exp_blue;
      logic [7:0] exp_green;
      logic [7:0] exp_red;
      logic       exp_last;
   } pixel_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_push = 1'b0;
   logic                     req_full;
   logic [7:0]               req_blue_in = '0;
   logic [7:0]               req_green_in = '0;
   logic [7:0]               req_red_in = '0;
   logic                     req_is_pad = 1'b0;
   logic                     rsp_empty;
   logic                     rsp_pop = 1'b0;
   logic [7:0]               rsp_blue_out;
   logic [7:0]               rsp_green_out;
   logic [7:0]               rsp_red_out;
   logic                     rsp_frame_last;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   pixel_word_type pixel_feed[$];
   pixel_word_type filtered_pending[$];

   // predictor state
   logic [23:0]    line_store [5][STORE_WIDTH];
   int             in_col, in_row, out_col, out_row;
   logic [1:0]     cfg_mode;
   logic [11:0]    cfg_width;
   logic [12:0]    cfg_height;
   logic [3:0]     cfg_cgain;
   logic [3:0]     cfg_sgain;

   int send_idle = 0;
   int recv_idle = 0;
   int mismatches = 0;
   int results_seen = 0;
   int frames_seen = 0;
   int words_sent = 0;
   int cycles = 0;

   window_convolution_filter i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_blue_in    (req_blue_in),
      .req_green_in   (req_green_in),
      .req_red_in     (req_red_in),
      .req_is_pad     (req_is_pad),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_red_out    (rsp_red_out),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic longint clamp_pixel(input longint v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
   endfunction

   // advance the filter by one word; returns 1 when a filtered pixel leaves
   function automatic bit filter_pixel(input logic [23:0] pix, input logic pad,
                                       output logic [24:0] res);
      int     w, h, rad, yy, xx;
      bit     cont;
      longint lag, in_lin, out_lin, wsum, wt, g, v, c;
      longint acc [3];
      longint chan [3];
      logic [23:0] px;
      w = (cfg_width == 0) ? 1 : ((cfg_width > STORE_WIDTH) ? STORE_WIDTH : cfg_width);
      h = (cfg_height == 0) ? 1 : cfg_height;
      cont = (cfg_mode == MODE_CONTOUR);
      rad = cont ? 1 : 2;
      g = cfg_cgain;
      res = '0;
      if (out_row >= h) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
      if (in_row < h) begin
         if (pad) return 0;
         line_store[in_row % 5][in_col] = pix;
      end
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      lag = rad * w + rad;
      in_lin = longint'(in_row) * w + in_col;
      out_lin = longint'(out_row) * w + out_col;
      if (in_lin <= out_lin + lag) return 0;

      // weighted window, skipping taps outside the image
      acc[0] = 0; acc[1] = 0; acc[2] = 0;
      wsum = 0;
      for (int dy = -rad; dy <= rad; dy++) begin
         for (int dx = -rad; dx <= rad; dx++) begin
            yy = out_row + dy;
            xx = out_col + dx;
            if (yy < 0 || yy >= h || xx < 0 || xx >= w) continue;
            px = line_store[yy % 5][xx];
            if (cont) wt = (dy == 0 && dx == 0) ? 8 * g : -g;
            else wt = 1;
            wsum += wt;
            for (int k = 0; k < 3; k++) begin
               c = px[8*k +: 8];
               acc[k] += wt * c;
            end
         end
      end
      for (int k = 0; k < 3; k++) begin
         v = acc[k];
         if (wsum != 0) v = v / wsum;
         chan[k] = clamp_pixel(v);
      end
      // unsharp mask on top of the blur
      if (cfg_mode == MODE_SHARPEN) begin
         px = line_store[out_row % 5][out_col];
         for (int k = 0; k < 3; k++) begin
            c = px[8*k +: 8];
            chan[k] = clamp_pixel(chan[k] + (c - chan[k]) * longint'(cfg_sgain));
         end
      end
      res[7:0] = chan[0][7:0];
      res[15:8] = chan[1][7:0];
      res[23:16] = chan[2][7:0];
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      if (out_row >= h) begin
         res[24] = 1'b1;
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
      return 1;
   endfunction

   // queue one word together with its predicted result
   task automatic queue_word(input logic [23:0] pix, input logic pad, output bit last);
      pixel_word_type wd;
      logic [24:0] res;
      wd.blue = pix[7:0];
      wd.green = pix[15:8];
      wd.red = pix[23:16];
      wd.pad = pad;
      wd.has_result = filter_pixel(pix, pad, res);
      wd.exp_blue = res[7:0];
      wd.exp_green = res[15:8];
      wd.exp_red = res[23:16];
      wd.exp_last = res[24];
      last = wd.has_result && res[24];
      pixel_feed.push_back(wd);
      words_sent++;
   endtask

   function automatic logic [23:0] pick_pixel(input bit extreme);
      logic [23:0] p;
      p = 24'($urandom);
      if (extreme) begin
         for (int k = 0; k < 3; k++)
            if ($urandom_range(1)) p[8*k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      return p;
   endfunction

   // one whole frame: pixels with stray pads, then drain words to frame end
   task automatic queue_frame(input bit extreme);
      int  w, h;
      bit  last;
      w = (cfg_width == 0) ? 1 : ((cfg_width > STORE_WIDTH) ? STORE_WIDTH : cfg_width);
      h = (cfg_height == 0) ? 1 : cfg_height;
      last = 0;
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(15) == 0) queue_word(pick_pixel(0), 1'b1, last);
         queue_word(pick_pixel(extreme), 1'b0, last);
      end
      while (!last) queue_word(pick_pixel(0), 1'($urandom_range(1)), last);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FILTER_MODE:  cfg_mode = data[1:0];
         CSR_IMAGE_WIDTH:  cfg_width = data[11:0];
         CSR_IMAGE_HEIGHT: cfg_height = data[12:0];
         CSR_CONTOUR_GAIN: cfg_cgain = data[3:0];
         CSR_SHARPEN_GAIN: cfg_sgain = data[3:0];
         default: ;
      endcase
   endtask

   // program all registers while idle, then stream frames and wait to drain
   task automatic run_phase(input int mode, input int w, input int h, input int cg,
                            input int sg, input int frames, input bit extreme);
      csr_write(CSR_FILTER_MODE, 13'(mode));
      csr_write(CSR_IMAGE_WIDTH, 13'(w));
      csr_write(CSR_IMAGE_HEIGHT, 13'(h));
      csr_write(CSR_CONTOUR_GAIN, 13'(cg));
      csr_write(CSR_SHARPEN_GAIN, 13'(sg));
      csr_valid <= 1'b0;
      for (int f = 0; f < frames; f++) queue_frame(extreme);
      while (pixel_feed.size() != 0 || filtered_pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // sender: hold a word until taken, idle at random between words
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || !req_full) begin
         if (req_push) begin
            if (pixel_feed[0].has_result) filtered_pending.push_back(pixel_feed[0]);
            void'(pixel_feed.pop_front());
         end
         if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_push <= 1'b1;
            req_blue_in <= pixel_feed[0].blue;
            req_green_in <= pixel_feed[0].green;
            req_red_in <= pixel_feed[0].red;
            req_is_pad <= pixel_feed[0].pad;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // receiver: check each popped word against the oldest prediction
   always @(posedge clock) begin
      pixel_word_type ex;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (rsp_frame_last) frames_seen++;
            if (filtered_pending.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected word: b=%0d g=%0d r=%0d last=%0d",
                           rsp_blue_out, rsp_green_out, rsp_red_out, rsp_frame_last);
            end else begin
               ex = filtered_pending.pop_front();
               if (rsp_blue_out !== ex.exp_blue || rsp_green_out !== ex.exp_green ||
                   rsp_red_out !== ex.exp_red || rsp_frame_last !== ex.exp_last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch: exp %0d/%0d/%0d last %0d, got %0d/%0d/%0d last %0d",
                              ex.exp_blue, ex.exp_green, ex.exp_red, ex.exp_last,
                              rsp_blue_out, rsp_green_out, rsp_red_out, rsp_frame_last);
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int phase;
      cfg_mode = RST_FILTER_MODE;
      cfg_width = RST_IMAGE_WIDTH;
      cfg_height = RST_IMAGE_HEIGHT;
      cfg_cgain = RST_CONTOUR_GAIN;
      cfg_sgain = RST_SHARPEN_GAIN;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every mode, gain extremes, zero geometry, saturated pixels
      send_idle = 30;
      recv_idle = 84;
      run_phase(MODE_BLUR, 5, 4, 3, 3, 1, 1);
      run_phase(MODE_CONTOUR, 4, 3, 15, 0, 1, 1);
      run_phase(MODE_CONTOUR, 3, 2, 0, 15, 1, 1);
      run_phase(MODE_SHARPEN, 3, 3, 7, 15, 1, 1);
      run_phase(3, 0, 0, 0, 0, 1, 1);

      // random geometry and gains, small frames; idle pattern follows progress
      phase = 0;
      while (words_sent < 520 || results_seen < 60) begin
         if (words_sent >= 340) begin
            send_idle = 0;
            recv_idle = 0;
         end else if (words_sent >= 180) begin
            send_idle = 84;
            recv_idle = 30;
         end
         run_phase($urandom_range(3), $urandom_range(1, 9), $urandom_range(1, 7),
                   $urandom_range(15), $urandom_range(15), $urandom_range(1, 2),
                   $urandom_range(1));
         phase++;
      end

      // geometry extremes: a single row and a single column
      send_idle = 0;
      recv_idle = 0;
      run_phase(MODE_SHARPEN, 9, 1, 15, 15, 1, 0);
      run_phase(MODE_CONTOUR, 1, 9, 15, 1, 1, 0);

      $display("%0d words sent over %0d phases; %0d filtered words and %0d frames checked",
               words_sent, phase + 7, results_seen, frames_seen);
      $display("all modes, gain and geometry extremes, pad draining and idle patterns covered");
      if (mismatches == 0 && filtered_pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d words still expected", mismatches,
                  filtered_pending.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/wcf_pkg.sv
hw/rtl/wcf_fifo.sv
hw/rtl/wcf_front.sv
hw/rtl/wcf_back.sv
hw/rtl/window_convolution_filter.sv
dv/testbench.sv
